// ===== sv/sri_pkg.sv =====
// Shared types and codes for the segment/rectangle intersection block
`timescale 1ns / 1ps

package sri_pkg;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_LEFT   = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_RIGHT  = 2'd3
  } edge_sel_t;

  typedef struct packed {
    logic      hit;
    logic      has_point;
    edge_sel_t edge_idx;
    logic      last;
  } res_ctrl_t;

endpackage

// ===== sv/sri_if.sv =====
// Valid/ready channel interfaces for segment items and crossing results
`timescale 1ns / 1ps

interface sri_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic signed [COORD_WIDTH-1:0] box_left;
  logic signed [COORD_WIDTH-1:0] box_top;
  logic        [COORD_WIDTH-2:0] box_width;
  logic        [COORD_WIDTH-2:0] box_height;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_left, box_top, box_width, box_height,
    input  ready
  );
  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           box_left, box_top, box_width, box_height,
    output ready
  );
endinterface

interface sri_out_if #(
  parameter int COORD_WIDTH = 16
) ();
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          has_point;
  logic [1:0]                    edge_index;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last;

  modport source (
    output valid, hit, has_point, edge_index, point_x, point_y, last,
    input  ready
  );
  modport sink (
    input  valid, hit, has_point, edge_index, point_x, point_y, last,
    output ready
  );
endinterface

// ===== sv/sri_front.sv =====
// Front end: accept items, walk the top, left, bottom and right edges and classify each crossing
`timescale 1ns / 1ps

module sri_front import sri_pkg::*; #(
  parameter int CW = 16,
  parameter int EW = 5 + 4 * (4 * CW + 2)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] seg_start_x,
  input  logic signed [CW-1:0] seg_start_y,
  input  logic signed [CW-1:0] seg_end_x,
  input  logic signed [CW-1:0] seg_end_y,
  input  logic signed [CW-1:0] box_left,
  input  logic signed [CW-1:0] box_top,
  input  logic        [CW-2:0] box_width,
  input  logic        [CW-2:0] box_height,
  output logic                 push_valid,
  input  logic                 push_ready,
  output logic [EW-1:0]        push_data
);

  localparam int PW   = 2 * CW + 2;
  localparam int NUMW = 2 * CW + 1;

  typedef struct packed {
    logic signed [NUMW-1:0] num;
    logic        [CW-1:0]   ra;
    logic signed [CW:0]     c;
  } edge_rec_t;

  typedef struct packed {
    logic            in_box;
    logic [3:0]      got;
    edge_rec_t [3:0] e;
  } item_rec_t;

  // input item capture
  logic signed [CW:0] sx_e, sy_e, ex_e, ey_e, bx_e, by_e, right_in, low_in;
  logic               inside_in;
  logic               adv;

  logic               it_v_r;
  edge_sel_t          k_r;
  logic signed [CW-1:0] px_r, py_r;
  logic signed [CW:0]   rx_r, ry_r, bx_r, by_r, right_r, low_r;
  logic               bwz_r, bhz_r, inside_r;

  assign sx_e     = {seg_start_x[CW-1], seg_start_x};
  assign sy_e     = {seg_start_y[CW-1], seg_start_y};
  assign ex_e     = {seg_end_x[CW-1], seg_end_x};
  assign ey_e     = {seg_end_y[CW-1], seg_end_y};
  assign bx_e     = {box_left[CW-1], box_left};
  assign by_e     = {box_top[CW-1], box_top};
  assign right_in = bx_e + $signed({2'b00, box_width});
  assign low_in   = by_e - $signed({2'b00, box_height});
  assign inside_in = ((sx_e >= bx_e) && (sx_e <= right_in) &&
                      (sy_e >= low_in) && (sy_e <= by_e)) ||
                     ((ex_e >= bx_e) && (ex_e <= right_in) &&
                      (ey_e >= low_in) && (ey_e <= by_e));

  assign in_ready = !it_v_r || (adv && k_r == EDGE_RIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      it_v_r <= 1'b0;
      k_r    <= EDGE_TOP;
    end else if (in_valid && in_ready) begin
      it_v_r <= 1'b1;
      k_r    <= EDGE_TOP;
    end else if (adv && it_v_r) begin
      k_r <= edge_sel_t'(k_r + 2'd1);
      if (k_r == EDGE_RIGHT) begin
        it_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px_r     <= seg_start_x;
      py_r     <= seg_start_y;
      rx_r     <= ex_e - sx_e;
      ry_r     <= ey_e - sy_e;
      bx_r     <= bx_e;
      by_r     <= by_e;
      right_r  <= right_in;
      low_r    <= low_in;
      bwz_r    <= (box_width == '0);
      bhz_r    <= (box_height == '0);
      inside_r <= inside_in;
    end
  end

  // edge selection and range test on the parameter along the segment
  logic                 even;
  logic signed [CW:0]   c_sel, ra_sel, rb_sel, lo_sel, hi_sel, ra_neg;
  logic signed [CW-1:0] pa_sel, pb_sel;
  logic signed [CW+1:0] d_pos, d_neg, d_use;
  logic                 spz, ok_nxt;
  logic [CW-1:0]        ra_abs;

  always_comb begin
    unique case (k_r)
      EDGE_TOP:    c_sel = by_r;
      EDGE_LEFT:   c_sel = bx_r;
      EDGE_BOTTOM: c_sel = low_r;
      EDGE_RIGHT:  c_sel = right_r;
      default:     c_sel = by_r;
    endcase
  end

  assign even   = !k_r[0];
  assign pa_sel = even ? py_r : px_r;
  assign pb_sel = even ? px_r : py_r;
  assign ra_sel = even ? ry_r : rx_r;
  assign rb_sel = even ? rx_r : ry_r;
  assign lo_sel = even ? bx_r : low_r;
  assign hi_sel = even ? right_r : by_r;
  assign spz    = even ? bwz_r : bhz_r;
  assign d_pos  = {c_sel[CW], c_sel} - {{2{pa_sel[CW-1]}}, pa_sel};
  assign d_neg  = {{2{pa_sel[CW-1]}}, pa_sel} - {c_sel[CW], c_sel};
  assign ra_neg = -ra_sel;
  assign ra_abs = ra_sel[CW] ? ra_neg[CW-1:0] : ra_sel[CW-1:0];
  assign d_use  = ra_sel[CW] ? d_neg : d_pos;
  assign ok_nxt = !spz && (ra_sel != '0) &&
                  (ra_sel[CW] ? (!d_neg[CW+1] && (d_pos >= ra_sel))
                              : (!d_pos[CW+1] && (d_pos <= ra_sel)));

  logic                 s1_v_r, s1_ok_r, s1_inside_r;
  edge_sel_t            s1_k_r;
  logic signed [CW-1:0] s1_pb_r;
  logic signed [CW:0]   s1_rb_r, s1_lo_r, s1_hi_r, s1_c_r;
  logic [CW-1:0]        s1_ra_r, s1_dn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= it_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_k_r      <= k_r;
      s1_ok_r     <= ok_nxt;
      s1_inside_r <= inside_r;
      s1_pb_r     <= pb_sel;
      s1_rb_r     <= rb_sel;
      s1_lo_r     <= lo_sel;
      s1_hi_r     <= hi_sel;
      s1_c_r      <= c_sel;
      s1_ra_r     <= ra_abs;
      s1_dn_r     <= d_use[CW-1:0];
    end
  end

  // products for the crossing numerator and the edge bounds
  logic signed [CW:0]   ra_s, dn_s;
  logic signed [PW-1:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;

  assign ra_s   = $signed({1'b0, s1_ra_r});
  assign dn_s   = $signed({1'b0, s1_dn_r});
  assign p1_nxt = s1_pb_r * ra_s;
  assign p2_nxt = dn_s * s1_rb_r;
  assign p3_nxt = s1_lo_r * ra_s;
  assign p4_nxt = s1_hi_r * ra_s;

  logic                 s2_v_r, s2_ok_r, s2_inside_r;
  edge_sel_t            s2_k_r;
  logic signed [PW-1:0] s2_p1_r, s2_p2_r, s2_p3_r, s2_p4_r;
  logic [CW-1:0]        s2_ra_r;
  logic signed [CW:0]   s2_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_k_r      <= s1_k_r;
      s2_ok_r     <= s1_ok_r;
      s2_inside_r <= s1_inside_r;
      s2_p1_r     <= p1_nxt;
      s2_p2_r     <= p2_nxt;
      s2_p3_r     <= p3_nxt;
      s2_p4_r     <= p4_nxt;
      s2_ra_r     <= s1_ra_r;
      s2_c_r      <= s1_c_r;
    end
  end

  // bound check and item assembly
  logic signed [PW-1:0] sum;
  logic                 got_now;
  edge_rec_t            cur;
  edge_rec_t            buf_r [3];
  logic [2:0]           got_r;
  logic [1:0]           slot;
  item_rec_t            item_nxt;

  assign sum       = s2_p1_r + s2_p2_r;
  assign got_now   = s2_ok_r && (sum >= s2_p3_r) && (sum <= s2_p4_r);
  assign cur.num   = sum[NUMW-1:0];
  assign cur.ra    = s2_ra_r;
  assign cur.c     = s2_c_r;
  assign slot      = s2_k_r;

  assign push_valid = s2_v_r && (s2_k_r == EDGE_RIGHT);
  assign adv        = !(push_valid && !push_ready);

  always_ff @(posedge clk) begin
    if (adv && s2_v_r && (s2_k_r != EDGE_RIGHT)) begin
      buf_r[slot] <= cur;
      got_r[slot] <= got_now;
    end
  end

  always_comb begin
    item_nxt.in_box = s2_inside_r;
    item_nxt.got    = {got_now, got_r};
    item_nxt.e[3]   = cur;
    item_nxt.e[2]   = buf_r[2];
    item_nxt.e[1]   = buf_r[1];
    item_nxt.e[0]   = buf_r[0];
  end

  assign push_data = item_nxt;

endmodule

// ===== sv/sri_queue.sv =====
// Two-entry item queue between the front and back ends
`timescale 1ns / 1ps

module sri_queue import sri_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, rp_r;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

// ===== sv/sri_back.sv =====
// Back end: issue crossings, divide through a bit-per-stage pipeline, register results
`timescale 1ns / 1ps

module sri_back import sri_pkg::*; #(
  parameter int CW = 16,
  parameter int EW = 5 + 4 * (4 * CW + 2)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [EW-1:0] q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output res_ctrl_t     out_ctrl,
  output logic [CW-1:0] out_x,
  output logic [CW-1:0] out_y
);

  localparam int NUMW = 2 * CW + 1;
  localparam int RW   = 2 * CW;

  typedef struct packed {
    logic signed [NUMW-1:0] num;
    logic        [CW-1:0]   ra;
    logic signed [CW:0]     c;
  } edge_rec_t;

  typedef struct packed {
    logic            in_box;
    logic [3:0]      got;
    edge_rec_t [3:0] e;
  } item_rec_t;

  function automatic logic [CW-1:0] sat(input logic signed [CW:0] v);
    logic [CW-1:0] r;
    if (v[CW] != v[CW-1]) begin
      r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  logic      en;
  logic      out_v_r;
  item_rec_t head;
  logic [3:0] done_r, remaining, sel, after;
  edge_sel_t idx;
  logic      last_op, has_pt;
  edge_rec_t er;
  logic signed [NUMW-1:0] num_neg;
  res_ctrl_t ctrl0;

  assign en        = !out_v_r || out_ready;
  assign head      = q_data;
  assign remaining = head.got & ~done_r;
  assign sel       = remaining & (~remaining + 4'd1);
  assign after     = remaining & ~sel;
  assign last_op   = (after == 4'd0);
  assign has_pt    = (remaining != 4'd0);
  assign q_pop     = q_valid && en && last_op;

  always_comb begin
    if (sel[1]) begin
      idx = EDGE_LEFT;
    end else if (sel[2]) begin
      idx = EDGE_BOTTOM;
    end else if (sel[3]) begin
      idx = EDGE_RIGHT;
    end else begin
      idx = EDGE_TOP;
    end
  end

  assign er      = head.e[idx];
  assign num_neg = -er.num;

  always_comb begin
    ctrl0.hit       = has_pt || head.in_box;
    ctrl0.has_point = has_pt;
    ctrl0.edge_idx  = idx;
    ctrl0.last      = last_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 4'd0;
    end else if (q_pop) begin
      done_r <= 4'd0;
    end else if (q_valid && en) begin
      done_r <= done_r | sel;
    end
  end

  // divider pipeline, one quotient bit per stage
  logic                 v_r   [CW+1];
  logic [RW-1:0]        rem_r [CW+1];
  logic [CW-1:0]        q_r   [CW+1];
  logic [CW-1:0]        dv_r  [CW+1];
  logic                 sg_r  [CW+1];
  logic signed [CW:0]   c_r   [CW+1];
  res_ctrl_t            ct_r  [CW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= er.num[NUMW-1] ? num_neg[RW-1:0] : er.num[RW-1:0];
      q_r[0]   <= '0;
      dv_r[0]  <= er.ra;
      sg_r[0]  <= er.num[NUMW-1];
      c_r[0]   <= er.c;
      ct_r[0]  <= ctrl0;
    end
  end

  for (genvar s = 0; s < CW; s++) begin : g_div
    localparam int J = CW - 1 - s;
    logic [RW-1:0] dsh;
    logic          ge;

    assign dsh = {{CW{1'b0}}, dv_r[s]} << J;
    assign ge  = (rem_r[s] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= ge ? (rem_r[s] - dsh) : rem_r[s];
        q_r[s+1]   <= q_r[s] | ({{(CW-1){1'b0}}, ge} << J);
        dv_r[s+1]  <= dv_r[s];
        sg_r[s+1]  <= sg_r[s];
        c_r[s+1]   <= c_r[s];
        ct_r[s+1]  <= ct_r[s];
      end
    end
  end

  // result register
  logic signed [CW:0] at_pos, at, xf, yf;
  res_ctrl_t          ctf;
  res_ctrl_t          out_ctrl_r;
  logic [CW-1:0]      out_x_r, out_y_r;

  assign ctf    = ct_r[CW];
  assign at_pos = $signed({1'b0, q_r[CW]});
  assign at     = sg_r[CW] ? -at_pos : at_pos;
  assign xf     = ctf.edge_idx[0] ? c_r[CW] : at;
  assign yf     = ctf.edge_idx[0] ? at : c_r[CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= v_r[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctrl_r <= ctf;
      out_x_r    <= ctf.has_point ? sat(xf) : '0;
      out_y_r    <= ctf.has_point ? sat(yf) : '0;
    end
  end

  assign out_valid = out_v_r;
  assign out_ctrl  = out_ctrl_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;

endmodule

// ===== sv/segment_rect_intersect_core.sv =====
// Top level of the segment versus axis-aligned rectangle intersection core
//
// in_ch carries one segment and one rectangle per item (signed fixed point,
// box_width/box_height unsigned, y grows upward, the box hangs down from
// box_top). out_ch returns one result per edge crossed, in the order top,
// left, bottom, right, with last set on the final one; an item with no
// crossing returns a single result with has_point clear and hit set only
// when an endpoint lies inside the rectangle.
// The front end takes a new item only as it walks the last edge of the
// current one; it walks the edges one per cycle while the queue accepts,
// through a single set of multipliers. Results leave at one per cycle while
// out_ch is ready, from a divider pipeline of CW stages (COORD_WIDTH clamped
// to 2..31).
// Reset clears valid flags, counters, pointers and done_r; data needs no reset.
// When out_ch stalls, the result register and divider pipeline hold, the
// two-item queue fills, and then in_ch.ready drops.
`timescale 1ns / 1ps

module segment_rect_intersect_core import sri_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  sri_in_if.sink    in_ch,
  sri_out_if.source out_ch
);

  localparam int CW   = (COORD_WIDTH > 31) ? 31 : ((COORD_WIDTH < 2) ? 2 : COORD_WIDTH);
  localparam int WW   = CW - 1;
  localparam int NUMW = 2 * CW + 1;
  localparam int EW   = 5 + 4 * (NUMW + CW + CW + 1);

  logic          push_valid, push_ready, q_valid, q_pop;
  logic [EW-1:0] push_data, q_data;
  res_ctrl_t     res_ctrl;
  logic [CW-1:0] res_x, res_y;

  sri_front #(.CW(CW), .EW(EW)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .seg_start_x (CW'(in_ch.seg_start_x)),
    .seg_start_y (CW'(in_ch.seg_start_y)),
    .seg_end_x   (CW'(in_ch.seg_end_x)),
    .seg_end_y   (CW'(in_ch.seg_end_y)),
    .box_left    (CW'(in_ch.box_left)),
    .box_top     (CW'(in_ch.box_top)),
    .box_width   (WW'(in_ch.box_width)),
    .box_height  (WW'(in_ch.box_height)),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_data   (push_data)
  );

  sri_queue #(.W(EW)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  sri_back #(.CW(CW), .EW(EW)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_ctrl  (res_ctrl),
    .out_x     (res_x),
    .out_y     (res_y)
  );

  assign out_ch.hit        = res_ctrl.hit;
  assign out_ch.has_point  = res_ctrl.has_point;
  assign out_ch.edge_index = res_ctrl.edge_idx;
  assign out_ch.last       = res_ctrl.last;
  assign out_ch.point_x    = COORD_WIDTH'(res_x);
  assign out_ch.point_y    = COORD_WIDTH'(res_y);

endmodule

// ===== sv/sri_checker.sv =====
// Port-level checks for the intersection core, bound to its top level
`timescale 1ns / 1ps

module sri_checker import sri_pkg::*; #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_hit,
  input logic                   out_has_point,
  input logic [1:0]             out_edge_index,
  input logic [COORD_WIDTH-1:0] out_point_x,
  input logic [COORD_WIDTH-1:0] out_point_y,
  input logic                   out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_x) &&
      $stable(out_point_y) && $stable(out_last) && $stable(out_has_point))
    else $error("result changed while stalled");

  a_nopoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_point |-> out_last && (out_edge_index == EDGE_TOP) &&
      (out_point_x == '0) && (out_point_y == '0))
    else $error("result without a point is not a clean final item");

  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_point |-> out_hit)
    else $error("crossing point without hit");

  a_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !out_valid || out_has_point)
    else $error("non-final result followed by a result without a point");

endmodule

bind segment_rect_intersect_core sri_checker #(.COORD_WIDTH(COORD_WIDTH)) u_sri_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_has_point  (out_ch.has_point),
  .out_edge_index (out_ch.edge_index),
  .out_point_x    (out_ch.point_x),
  .out_point_y    (out_ch.point_y),
  .out_last       (out_ch.last)
);
